FILE: sv/fpalu_pkg.sv
// Shared types and constants of the fixed-point ALU with sticky error code.
`default_nettype none
package fpalu_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_W         = 32;
    localparam int CMD_W          = 4;
    localparam int ERR_W          = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_UADD = 4'd0,
        CMD_SADD = 4'd1,
        CMD_USUB = 4'd2,
        CMD_SSUB = 4'd3,
        CMD_UMUL = 4'd4,
        CMD_SMUL = 4'd5,
        CMD_UDIV = 4'd6,
        CMD_SDIV = 4'd7,
        CMD_CLR  = 4'd8
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE = 2'd0,
        ERR_OVF  = 2'd1,
        ERR_DIV0 = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        UM_ADDSUB,
        UM_MUL,
        UM_DIV
    } t_umode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] result_word;
        logic [ERR_W-1:0]  error_code;
    } t_out;

    typedef struct packed {
        logic   start;
        t_umode mode;
    } t_req;

    typedef struct packed {
        logic   load;
        logic   step;
        t_umode mode;
    } t_ctrl;

    typedef struct packed {
        logic ready;
        logic finish;
    } t_stat;

endpackage
`default_nettype wire

FILE: sv/fpalu_unit.sv
// Shared adder with shift-add multiply and restoring divide iteration registers.
`default_nettype none
module fpalu_unit #(
    parameter int W = fpalu_pkg::WORD_WIDTH_DEF,
    parameter int F = fpalu_pkg::FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire fpalu_pkg::t_ctrl i_ctrl,
    input  wire logic             i_sub,
    input  wire logic [W-1:0]     i_ma,
    input  wire logic [W-1:0]     i_mb,
    output logic      [W+1:0]     o_sum,
    output logic      [2*W-1:0]   o_prod,
    output logic      [W-1:0]     o_quot
);

    localparam int QW = W + F;

    logic [W-1:0]  r_hi, n_hi;
    logic [QW-1:0] r_lo, n_lo;
    logic [W:0]    add_x, add_y;
    logic          add_sub;
    logic [W+1:0]  add_res;

    always_comb begin
        unique case (i_ctrl.mode)
            fpalu_pkg::UM_MUL: begin
                add_x   = {1'b0, r_hi};
                add_y   = r_lo[0] ? {1'b0, i_ma} : '0;
                add_sub = 1'b0;
            end
            fpalu_pkg::UM_DIV: begin
                add_x   = {r_hi, r_lo[QW-1]};
                add_y   = {1'b0, i_mb};
                add_sub = 1'b1;
            end
            default: begin
                add_x   = {1'b0, i_ma};
                add_y   = {1'b0, i_mb};
                add_sub = i_sub;
            end
        endcase
        add_res = {1'b0, add_x} + {1'b0, add_y ^ {(W+1){add_sub}}} + (W+2)'(add_sub);
    end

    always_comb begin
        n_hi = r_hi;
        n_lo = r_lo;
        if (i_ctrl.load) begin
            n_hi = '0;
            if (i_ctrl.mode == fpalu_pkg::UM_MUL) begin
                n_lo = QW'(i_mb);
            end else begin
                n_lo = {i_ma, {F{1'b0}}};
            end
        end else if (i_ctrl.step) begin
            if (i_ctrl.mode == fpalu_pkg::UM_MUL) begin
                n_hi = add_res[W:1];
                n_lo = {r_lo[QW-1:W], add_res[0], r_lo[W-1:1]};
            end else begin
                n_hi = add_res[W+1] ? add_res[W-1:0] : add_x[W-1:0];
                n_lo = {r_lo[QW-2:0], add_res[W+1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
    end

    assign o_sum  = add_res;
    assign o_prod = {r_hi, r_lo[W-1:0]};
    assign o_quot = r_lo[W-1:0];

endmodule
`default_nettype wire

FILE: sv/fpalu_seq.sv
// Sequencer: load, per-bit iteration count and result hand-off.
`default_nettype none
module fpalu_seq #(
    parameter int W = fpalu_pkg::WORD_WIDTH_DEF,
    parameter int F = fpalu_pkg::FRAC_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire fpalu_pkg::t_req i_req,
    input  wire logic            i_out_free,
    output fpalu_pkg::t_ctrl     o_ctrl,
    output fpalu_pkg::t_stat     o_stat
);

    localparam int CW = $clog2(W + F);

    fpalu_pkg::t_state r_state, n_state;
    fpalu_pkg::t_umode r_mode, n_mode;
    logic [CW-1:0]     r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpalu_pkg::ST_IDLE;
            r_mode  <= fpalu_pkg::UM_ADDSUB;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_cnt         = r_cnt;
        o_ctrl.load   = 1'b0;
        o_ctrl.step   = 1'b0;
        o_ctrl.mode   = r_mode;
        o_stat.ready  = 1'b0;
        o_stat.finish = 1'b0;
        unique case (r_state)
            fpalu_pkg::ST_IDLE: begin
                o_stat.ready = 1'b1;
                if (i_req.start) begin
                    n_mode  = i_req.mode;
                    n_state = (i_req.mode == fpalu_pkg::UM_ADDSUB) ?
                              fpalu_pkg::ST_DONE : fpalu_pkg::ST_LOAD;
                end
            end
            fpalu_pkg::ST_LOAD: begin
                o_ctrl.load = 1'b1;
                n_cnt       = (r_mode == fpalu_pkg::UM_MUL) ? CW'(W - 1) : CW'(W + F - 1);
                n_state     = fpalu_pkg::ST_RUN;
            end
            fpalu_pkg::ST_RUN: begin
                o_ctrl.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = fpalu_pkg::ST_DONE;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            fpalu_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_stat.finish = 1'b1;
                    n_state       = fpalu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpalu_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/fixed_point_alu_sticky_error_core.sv
// Usage: Q-format fixed-point ALU with sticky error code, one result beat per input beat.
// Input channel i_in_valid / o_in_ready / i_in_data carries cmd and two raw operand words;
// only the low WORD_WIDTH bits of each operand are used, FRAC_BITS of them fraction.
// Output channel o_out_valid / i_out_ready / o_out_data returns the wrapped result word
// and the error code after this beat (0 none, 1 overflow, 2 divide by zero).
// One item is in flight at a time; o_in_ready is high only while the block is idle.
// Add, subtract, clear and unused codes: the sequencer passes from idle straight to its final
// state, skipping the load and iteration states.
// Multiply: one shift-add step per multiplier bit on the shared adder.
// Divide: one restoring step per quotient bit on the same adder; a zero divisor skips
// the load and iteration states, as an add does.
// A finished result waits in the output register while the receiver stalls, and the
// sequencer holds in its final state until that register frees up.
// Reset clears the error code to none and empties the output register.
`default_nettype none
module fixed_point_alu_sticky_error_core #(
    parameter int WORD_WIDTH = fpalu_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = fpalu_pkg::FRAC_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire fpalu_pkg::t_in i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output fpalu_pkg::t_out     o_out_data
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int XW = 2 * W + F;
    localparam logic [XW-1:0] HALF = {{(XW-1){1'b0}}, 1'b1} << (W - 1);

    fpalu_pkg::t_req  req;
    fpalu_pkg::t_ctrl ctrl;
    fpalu_pkg::t_stat stat;

    fpalu_pkg::t_cmd  in_cmd;
    logic [W-1:0]     in_a, in_b;
    logic             in_signed_md;
    logic             accept;
    logic             out_free;

    fpalu_pkg::t_cmd  r_cmd;
    logic [W-1:0]     r_ma, r_mb;
    logic             r_sa, r_sb, r_bz;
    fpalu_pkg::t_err  r_err, n_err;
    logic             r_out_valid;
    fpalu_pkg::t_out  r_out;

    logic [W+1:0]     sum;
    logic [2*W-1:0]   prod;
    logic [W-1:0]     quot;
    logic [XW-1:0]    p_ext, q_floor, q_up;
    logic             frac_nz, neg, ovf;
    logic [W-1:0]     n_res;

    assign in_cmd       = fpalu_pkg::t_cmd'(i_in_data.cmd);
    assign in_a         = i_in_data.operand_a[W-1:0];
    assign in_b         = i_in_data.operand_b[W-1:0];
    assign in_signed_md = (in_cmd == fpalu_pkg::CMD_SMUL) || (in_cmd == fpalu_pkg::CMD_SDIV);
    assign accept       = i_in_valid && o_in_ready;
    assign out_free     = !r_out_valid || i_out_ready;

    always_comb begin
        req.start = accept;
        case (in_cmd) inside
            fpalu_pkg::CMD_UMUL, fpalu_pkg::CMD_SMUL: req.mode = fpalu_pkg::UM_MUL;
            fpalu_pkg::CMD_UDIV, fpalu_pkg::CMD_SDIV:
                req.mode = (in_b == '0) ? fpalu_pkg::UM_ADDSUB : fpalu_pkg::UM_DIV;
            default: req.mode = fpalu_pkg::UM_ADDSUB;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= in_cmd;
            r_sa  <= in_a[W-1];
            r_sb  <= in_b[W-1];
            r_bz  <= (in_b == '0);
            r_ma  <= (in_signed_md && in_a[W-1]) ? (W'(0) - in_a) : in_a;
            r_mb  <= (in_signed_md && in_b[W-1]) ? (W'(0) - in_b) : in_b;
        end
    end

    fpalu_seq #(
        .W (W),
        .F (F)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_out_free (out_free),
        .o_ctrl     (ctrl),
        .o_stat     (stat)
    );

    fpalu_unit #(
        .W (W),
        .F (F)
    ) u_unit (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_sub  ((r_cmd == fpalu_pkg::CMD_USUB) || (r_cmd == fpalu_pkg::CMD_SSUB)),
        .i_ma   (r_ma),
        .i_mb   (r_mb),
        .o_sum  (sum),
        .o_prod (prod),
        .o_quot (quot)
    );

    always_comb begin
        p_ext   = XW'(prod);
        q_floor = p_ext >> F;
        frac_nz = |p_ext[F-1:0];
        q_up    = q_floor + XW'(frac_nz);
        neg     = (r_sa != r_sb) && (prod != '0);
        ovf     = 1'b0;
        n_res   = '0;
        n_err   = r_err;
        case (r_cmd) inside
            fpalu_pkg::CMD_UADD: begin
                n_res = sum[W-1:0];
                ovf   = sum[W];
            end
            fpalu_pkg::CMD_SADD: begin
                n_res = sum[W-1:0];
                ovf   = (r_sa == r_sb) && (sum[W-1] != r_sa);
            end
            fpalu_pkg::CMD_USUB: begin
                n_res = sum[W-1:0];
                ovf   = !sum[W+1];
            end
            fpalu_pkg::CMD_SSUB: begin
                n_res = sum[W-1:0];
                ovf   = (r_sa != r_sb) && (sum[W-1] != r_sa);
            end
            fpalu_pkg::CMD_UMUL: begin
                n_res = q_floor[W-1:0];
                ovf   = |q_floor[XW-1:W];
            end
            fpalu_pkg::CMD_SMUL: begin
                if (neg) begin
                    n_res = W'(0) - q_up[W-1:0];
                    ovf   = q_up > HALF;
                end else begin
                    n_res = q_floor[W-1:0];
                    ovf   = q_floor >= HALF;
                end
            end
            fpalu_pkg::CMD_UDIV, fpalu_pkg::CMD_SDIV: begin
                if (r_bz) begin
                    n_err = fpalu_pkg::ERR_DIV0;
                end else if ((r_cmd == fpalu_pkg::CMD_SDIV) && (r_sa != r_sb)) begin
                    n_res = W'(0) - quot;
                end else begin
                    n_res = quot;
                end
            end
            fpalu_pkg::CMD_CLR: begin
                n_err = fpalu_pkg::ERR_NONE;
            end
            default: begin
                n_res = '0;
            end
        endcase
        if (ovf) begin
            n_err = fpalu_pkg::ERR_OVF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err       <= fpalu_pkg::ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (stat.finish) begin
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.finish) begin
            r_out.result_word <= fpalu_pkg::DATA_W'(n_res);
            r_out.error_code  <= n_err;
        end
    end

    assign o_in_ready  = stat.ready && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
